FILE: rtl/stc_pkg.sv
// Shared types and constants for the command line tokenizer.
// No dependencies; used by every module of the block.
package stc_pkg;

	localparam int MAX_PIPELINES = 16;
	localparam int MAX_COMMANDS  = 16;
	localparam int MAX_ARGS      = 64;

	localparam int PIPE_W = $clog2(MAX_PIPELINES + 1);
	localparam int CMD_W  = $clog2(MAX_COMMANDS + 1);
	localparam int ARG_W  = $clog2(MAX_ARGS + 1);

	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW    = $clog2(FQ_DEPTH);
	localparam int OQ_DEPTH = 2;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_PIPE  = 8'h7c;

	typedef enum logic [3:0] {
		ROLE_BLANK      = 4'd0,
		ROLE_WORD_START = 4'd1,
		ROLE_WORD_CONT  = 4'd2,
		ROLE_IN_NAME    = 4'd3,
		ROLE_OUT_NAME   = 4'd4,
		ROLE_APP_NAME   = 4'd5,
		ROLE_NAME_CONT  = 4'd6,
		ROLE_PIPE       = 4'd7,
		ROLE_SEMI       = 4'd8,
		ROLE_AMP        = 4'd9,
		ROLE_REDIRECT   = 4'd10,
		ROLE_IGNORED    = 4'd11,
		ROLE_LINE_END   = 4'd12
	} role_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_NO_IN_FILE = 3'd1,
		ERR_NO_OUT_FILE = 3'd2,
		ERR_PIPE_NO_CMD = 3'd3,
		ERR_SEMI_NO_CMD = 3'd4,
		ERR_TRAILING   = 3'd5,
		ERR_CAPACITY   = 3'd6
	} err_t;

	typedef enum logic [2:0] {
		SYM_NONE,
		SYM_AMP,
		SYM_GT,
		SYM_LT,
		SYM_PIPE,
		SYM_SEMI
	} sym_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_line;
	} item_t;

	typedef struct packed {
		logic       eol;
		logic       nul;
		logic       sp_any;
		logic       brk;
		sym_t       sym;
	} class_t;

	typedef struct packed {
		logic [3:0] role;
		logic [3:0] pipeline_index;
		logic [3:0] command_index;
		logic [5:0] argument_index;
		logic       background;
		logic [2:0] error_code;
		logic [4:0] pipeline_count;
		logic       line_done;
	} result_t;

endpackage

FILE: rtl/stc_front.sv
// Front end: accepts characters, classifies them and holds them in a short queue.
// Depends on stc_pkg.
module stc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  stc_pkg::item_t  item,
	output logic            cls_valid,
	input  logic            cls_ready,
	output stc_pkg::class_t cls
);

	stc_pkg::class_t             fq_q [stc_pkg::FQ_DEPTH];
	logic [stc_pkg::FQ_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [stc_pkg::FQ_AW:0]     cnt_q;
	stc_pkg::class_t             cls_new;
	logic                        do_wr, do_rd;

	always_comb begin
		cls_new.eol    = item.end_of_line;
		cls_new.nul    = item.ch == stc_pkg::CH_NUL;
		cls_new.sp_any = item.ch == stc_pkg::CH_SPACE ||
			(item.ch >= stc_pkg::CH_TAB && item.ch <= stc_pkg::CH_CR);
		cls_new.brk    = item.ch == stc_pkg::CH_SPACE || item.ch == stc_pkg::CH_TAB ||
			item.ch == stc_pkg::CH_NL;
		unique case (item.ch)
			stc_pkg::CH_AMP:  cls_new.sym = stc_pkg::SYM_AMP;
			stc_pkg::CH_GT:   cls_new.sym = stc_pkg::SYM_GT;
			stc_pkg::CH_LT:   cls_new.sym = stc_pkg::SYM_LT;
			stc_pkg::CH_PIPE: cls_new.sym = stc_pkg::SYM_PIPE;
			stc_pkg::CH_SEMI: cls_new.sym = stc_pkg::SYM_SEMI;
			default:          cls_new.sym = stc_pkg::SYM_NONE;
		endcase
	end

	assign full      = cnt_q == (stc_pkg::FQ_AW+1)'(stc_pkg::FQ_DEPTH);
	assign cls_valid = cnt_q != '0;
	assign cls       = fq_q[rd_ptr_q];
	assign do_wr     = push && !full;
	assign do_rd     = cls_valid && cls_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			fq_q[wr_ptr_q] <= cls_new;
	end

endmodule

FILE: rtl/stc_back.sv
// Back end: lexer state and index counters, with a two-word result queue.
// Depends on stc_pkg.
module stc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cls_valid,
	output logic             cls_ready,
	input  stc_pkg::class_t  cls,
	output logic             empty,
	input  logic             pop,
	output stc_pkg::result_t result
);

	typedef enum logic [2:0] {
		M_BETWEEN,
		M_WORD,
		M_NAME,
		M_AFTER_GT,
		M_AWAIT
	} mode_t;

	typedef enum logic [1:0] {
		K_NONE,
		K_IN,
		K_OUT,
		K_APP
	} kind_t;

	mode_t                       mode_q;
	kind_t                       kind_q;
	logic [stc_pkg::PIPE_W-1:0]  pipe_q;
	logic [stc_pkg::CMD_W-1:0]   cmd_q;
	logic [stc_pkg::ARG_W-1:0]   arg_q;
	logic [stc_pkg::CMD_W-1:0]   ncmd_q;
	logic                        bg_q;
	stc_pkg::err_t               err_q;

	mode_t                       mode_d;
	kind_t                       kind_d;
	logic [stc_pkg::PIPE_W-1:0]  pipe_d;
	logic [stc_pkg::CMD_W-1:0]   cmd_d;
	logic [stc_pkg::ARG_W-1:0]   arg_d;
	logic [stc_pkg::CMD_W-1:0]   ncmd_d;
	logic                        bg_d;
	stc_pkg::err_t               err_d;
	stc_pkg::result_t            res_d;

	stc_pkg::result_t            oq_q [stc_pkg::OQ_DEPTH];
	logic [stc_pkg::OQ_AW-1:0]   oq_wr_q, oq_rd_q;
	logic [stc_pkg::OQ_AW:0]     oq_cnt_q;
	logic                        take, do_pop;

	always_comb begin : lex_b
		stc_pkg::role_t              role;
		logic                        done;
		logic                        delim;
		logic [stc_pkg::PIPE_W-1:0]  cnt;
		logic [stc_pkg::ARG_W-1:0]   ai;

		mode_d = mode_q;
		kind_d = kind_q;
		pipe_d = pipe_q;
		cmd_d  = cmd_q;
		arg_d  = arg_q;
		ncmd_d = ncmd_q;
		bg_d   = bg_q;
		err_d  = err_q;
		role   = stc_pkg::ROLE_IGNORED;
		done   = 1'b0;
		delim  = cls.brk || cls.sym != stc_pkg::SYM_NONE;
		cnt    = '0;
		ai     = arg_q;

		if (cls.eol) begin
			if (err_q == stc_pkg::ERR_NONE) begin
				if (mode_q == M_AFTER_GT)
					err_d = stc_pkg::ERR_NO_OUT_FILE;
				else if (mode_q == M_AWAIT)
					err_d = kind_q == K_IN ? stc_pkg::ERR_NO_IN_FILE
						: stc_pkg::ERR_NO_OUT_FILE;
				else if (ncmd_q != '0 && arg_q == '0)
					err_d = stc_pkg::ERR_TRAILING;
			end
			if (err_d == stc_pkg::ERR_NONE)
				cnt = ncmd_q != '0 ? pipe_q + 1'b1 : pipe_q;
			role = stc_pkg::ROLE_LINE_END;
		end else if (err_q == stc_pkg::ERR_NONE && !cls.nul) begin
			if (mode_d == M_AFTER_GT) begin
				mode_d = M_AWAIT;
				if (cls.sym == stc_pkg::SYM_GT) begin
					kind_d = K_APP;
					role   = stc_pkg::ROLE_REDIRECT;
					done   = 1'b1;
				end else begin
					kind_d = K_OUT;
				end
			end
			if (!done && mode_d == M_AWAIT) begin
				if (cls.sp_any) begin
					role = stc_pkg::ROLE_BLANK;
					done = 1'b1;
				end else if (!delim) begin
					role = kind_d == K_IN ? stc_pkg::ROLE_IN_NAME
						: kind_d == K_APP ? stc_pkg::ROLE_APP_NAME : stc_pkg::ROLE_OUT_NAME;
					kind_d = K_NONE;
					mode_d = M_NAME;
					done   = 1'b1;
				end else begin
					kind_d = K_NONE;
					mode_d = M_BETWEEN;
				end
			end
			if (!done && (mode_d == M_WORD || mode_d == M_NAME)) begin
				if (!delim) begin
					role = mode_d == M_NAME ? stc_pkg::ROLE_NAME_CONT : stc_pkg::ROLE_WORD_CONT;
					done = 1'b1;
				end else begin
					mode_d = M_BETWEEN;
					if (cls.brk) begin
						role = stc_pkg::ROLE_BLANK;
						done = 1'b1;
					end
				end
			end
			if (!done) begin
				if (cls.sp_any) begin
					role = stc_pkg::ROLE_BLANK;
				end else begin
					unique case (cls.sym)
						stc_pkg::SYM_AMP: begin
							bg_d = 1'b1;
							role = stc_pkg::ROLE_AMP;
						end
						stc_pkg::SYM_GT: begin
							mode_d = M_AFTER_GT;
							role   = stc_pkg::ROLE_REDIRECT;
						end
						stc_pkg::SYM_LT: begin
							kind_d = K_IN;
							mode_d = M_AWAIT;
							role   = stc_pkg::ROLE_REDIRECT;
						end
						stc_pkg::SYM_PIPE: begin
							if (arg_q == '0) begin
								err_d = stc_pkg::ERR_PIPE_NO_CMD;
							end else if (cmd_q >= stc_pkg::CMD_W'(stc_pkg::MAX_COMMANDS - 1)) begin
								err_d = stc_pkg::ERR_CAPACITY;
							end else begin
								cmd_d = cmd_q + 1'b1;
								arg_d = '0;
								role  = stc_pkg::ROLE_PIPE;
							end
						end
						stc_pkg::SYM_SEMI: begin
							if (ncmd_q == '0) begin
								err_d = stc_pkg::ERR_SEMI_NO_CMD;
							end else if (pipe_q >=
								stc_pkg::PIPE_W'(stc_pkg::MAX_PIPELINES - 1)) begin
								err_d = stc_pkg::ERR_CAPACITY;
							end else begin
								pipe_d = pipe_q + 1'b1;
								cmd_d  = '0;
								arg_d  = '0;
								ncmd_d = '0;
								bg_d   = 1'b0;
								role   = stc_pkg::ROLE_SEMI;
							end
						end
						default: begin
							if (arg_q >= stc_pkg::ARG_W'(stc_pkg::MAX_ARGS)) begin
								err_d = stc_pkg::ERR_CAPACITY;
							end else begin
								if (arg_q == '0)
									ncmd_d = ncmd_q + 1'b1;
								arg_d  = arg_q + 1'b1;
								mode_d = M_WORD;
								role   = stc_pkg::ROLE_WORD_START;
							end
						end
					endcase
				end
			end
		end

		res_d.role           = role;
		res_d.error_code     = err_d;
		res_d.pipeline_count = 5'(cnt);
		res_d.line_done      = cls.eol;
		if (cls.eol || role == stc_pkg::ROLE_PIPE || role == stc_pkg::ROLE_SEMI) begin
			res_d.pipeline_index = 4'(pipe_q);
			res_d.command_index  = 4'(cmd_q);
			res_d.argument_index = 6'(arg_q);
			res_d.background     = bg_q;
		end else begin
			if ((role == stc_pkg::ROLE_WORD_START || role == stc_pkg::ROLE_WORD_CONT) &&
				arg_d != '0)
				ai = arg_d - 1'b1;
			else
				ai = arg_d;
			res_d.pipeline_index = 4'(pipe_d);
			res_d.command_index  = 4'(cmd_d);
			res_d.argument_index = 6'(ai);
			res_d.background     = bg_d;
		end

		if (cls.eol) begin
			mode_d = M_BETWEEN;
			kind_d = K_NONE;
			pipe_d = '0;
			cmd_d  = '0;
			arg_d  = '0;
			ncmd_d = '0;
			bg_d   = 1'b0;
			err_d  = stc_pkg::ERR_NONE;
		end
	end

	assign empty     = oq_cnt_q == '0;
	assign do_pop    = pop && !empty;
	assign cls_ready = oq_cnt_q != (stc_pkg::OQ_AW+1)'(stc_pkg::OQ_DEPTH) || do_pop;
	assign take      = cls_valid && cls_ready;
	assign result    = oq_q[oq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_BETWEEN;
			kind_q   <= K_NONE;
			pipe_q   <= '0;
			cmd_q    <= '0;
			arg_q    <= '0;
			ncmd_q   <= '0;
			bg_q     <= 1'b0;
			err_q    <= stc_pkg::ERR_NONE;
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (take) begin
				mode_q  <= mode_d;
				kind_q  <= kind_d;
				pipe_q  <= pipe_d;
				cmd_q   <= cmd_d;
				arg_q   <= arg_d;
				ncmd_q  <= ncmd_d;
				bg_q    <= bg_d;
				err_q   <= err_d;
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (do_pop)
				oq_rd_q <= oq_rd_q + 1'b1;
			if (take && !do_pop)
				oq_cnt_q <= oq_cnt_q + 1'b1;
			else if (do_pop && !take)
				oq_cnt_q <= oq_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			oq_q[oq_wr_q] <= res_d;
	end

endmodule

FILE: rtl/shell_command_line_tokenizer_core.sv
// Top level of the command line tokenizer: front classifier and back lexer.
// Depends on stc_pkg, stc_front and stc_back.
//
// Input channel: a word is one character or an end-of-line mark, offered on
// item with push; it is taken at a clock edge where push is high and full is
// low. Result channel: one result word per input word, in order, shown on
// result while empty is low and removed at an edge where pop is high.
// A word pushed into an idle block passes the front queue register, then the
// result queue register, before it shows on result, and can then be popped.
// Throughput: one word per cycle while pop keeps up, set by the back-end lexer;
// the four-word front queue and two-word result queue absorb stalls.
// When pop is held low the result queue fills, the back end stops pulling
// from the front queue, and full rises once four more words are waiting.
// Reset clears both queues and all lexer state; the end-of-line word also
// returns the lexer state to its reset values after reporting.
module shell_command_line_tokenizer_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  stc_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output stc_pkg::result_t result
);

	logic            cls_valid;
	logic            cls_ready;
	stc_pkg::class_t cls;

	stc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cls_valid (cls_valid),
		.cls_ready (cls_ready),
		.cls       (cls)
	);

	stc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_valid (cls_valid),
		.cls_ready (cls_ready),
		.cls       (cls),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

FILE: rtl/stc_checker.sv
// Port-level checks for the tokenizer top level, and the bind that attaches them.
// Depends on stc_pkg and shell_command_line_tokenizer_core.
module stc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             empty,
	input logic             pop,
	input stc_pkg::result_t result
);

	a_role_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.role <= stc_pkg::ROLE_LINE_END)
		else $error("role out of range");

	a_done_role: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.line_done == (result.role == stc_pkg::ROLE_LINE_END)))
		else $error("line_done and line-end role disagree");

	a_count_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.pipeline_count != '0 |-> result.line_done)
		else $error("pipeline count outside line end");

	a_count_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.line_done && result.error_code != stc_pkg::ERR_NONE
		|-> result.pipeline_count == '0)
		else $error("pipeline count reported with an error");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result word changed");

endmodule

bind shell_command_line_tokenizer_core stc_checker u_stc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

FILE: dv/shell_command_line_tokenizer_core_tb.sv
// Self-checking bench for the command line tokenizer: random and directed lines
// checked against a behavioural lexer written here. Needs stc_pkg and the core.
`timescale 1ns / 1ps

module shell_command_line_tokenizer_core_tb;
	import stc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AT     = 280;
	localparam int HOLD_CYCLES = 90;

	typedef enum logic [2:0] {
		LM_BETWEEN, LM_WORD, LM_NAME, LM_AFTER_GT, LM_AWAIT
	} lex_mode_t;

	typedef enum logic [1:0] {
		NK_NONE, NK_IN, NK_OUT, NK_APP
	} name_kind_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    full;
	item_t   item = '0;
	logic    empty;
	logic    pop = 1'b0;
	result_t result;

	shell_command_line_tokenizer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// lexer state mirrored by the predictor
	lex_mode_t         mode;
	name_kind_t        pend_kind;
	logic [PIPE_W-1:0] pipe_no;
	logic [CMD_W-1:0]  cmd_no;
	logic [ARG_W-1:0]  arg_no;
	logic [CMD_W-1:0]  cmds_in_pipe;
	logic              bg;
	err_t              err_latch;

	item_t   line_chars[$];
	result_t awaited_results[$];

	int   queued_words = 0;
	int   lines_queued = 0;
	int   results_checked = 0;
	int   mismatches = 0;
	int   cycle_count = 0;
	logic in_taken = 1'b0;
	int   burst_left = 5;
	int   gap_left = 0;
	int   hold_left = 0;
	bit   hold_done = 1'b0;
	logic [9:0] rx_phase = '0;

	function automatic void clear_lexer();
		mode         = LM_BETWEEN;
		pend_kind    = NK_NONE;
		pipe_no      = '0;
		cmd_no       = '0;
		arg_no       = '0;
		cmds_in_pipe = '0;
		bg           = 1'b0;
		err_latch    = ERR_NONE;
	endfunction

	function automatic bit blank_any(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit ends_token(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_PIPE ||
			c == CH_AMP || c == CH_LT || c == CH_GT || c == CH_SEMI;
	endfunction

	function automatic role_t lex_char(logic [7:0] c);
		if (mode == LM_AFTER_GT) begin
			mode = LM_AWAIT;
			if (c == CH_GT) begin
				pend_kind = NK_APP;
				return ROLE_REDIRECT;
			end
			pend_kind = NK_OUT;
		end
		if (mode == LM_AWAIT) begin
			if (blank_any(c))
				return ROLE_BLANK;
			if (!ends_token(c)) begin
				mode = LM_NAME;
				if (pend_kind == NK_IN) begin
					pend_kind = NK_NONE;
					return ROLE_IN_NAME;
				end
				if (pend_kind == NK_APP) begin
					pend_kind = NK_NONE;
					return ROLE_APP_NAME;
				end
				pend_kind = NK_NONE;
				return ROLE_OUT_NAME;
			end
			// empty name: symbol handled as itself
			pend_kind = NK_NONE;
			mode = LM_BETWEEN;
		end
		if (mode == LM_WORD || mode == LM_NAME) begin
			if (!ends_token(c)) begin
				if (mode == LM_NAME)
					return ROLE_NAME_CONT;
				return ROLE_WORD_CONT;
			end
			mode = LM_BETWEEN;
			if (c == CH_SPACE || c == CH_TAB || c == CH_NL)
				return ROLE_BLANK;
		end
		if (blank_any(c))
			return ROLE_BLANK;
		case (c)
			CH_AMP: begin
				bg = 1'b1;
				return ROLE_AMP;
			end
			CH_GT: begin
				mode = LM_AFTER_GT;
				return ROLE_REDIRECT;
			end
			CH_LT: begin
				pend_kind = NK_IN;
				mode = LM_AWAIT;
				return ROLE_REDIRECT;
			end
			CH_PIPE: begin
				if (arg_no == 0) begin
					err_latch = ERR_PIPE_NO_CMD;
					return ROLE_IGNORED;
				end
				if (cmd_no + 1 >= MAX_COMMANDS) begin
					err_latch = ERR_CAPACITY;
					return ROLE_IGNORED;
				end
				cmd_no++;
				arg_no = '0;
				return ROLE_PIPE;
			end
			CH_SEMI: begin
				if (cmds_in_pipe == 0) begin
					err_latch = ERR_SEMI_NO_CMD;
					return ROLE_IGNORED;
				end
				if (pipe_no + 1 >= MAX_PIPELINES) begin
					err_latch = ERR_CAPACITY;
					return ROLE_IGNORED;
				end
				pipe_no++;
				cmd_no = '0;
				arg_no = '0;
				cmds_in_pipe = '0;
				bg = 1'b0;
				return ROLE_SEMI;
			end
			default: begin
				if (arg_no >= MAX_ARGS) begin
					err_latch = ERR_CAPACITY;
					return ROLE_IGNORED;
				end
				if (arg_no == 0)
					cmds_in_pipe++;
				arg_no++;
				mode = LM_WORD;
				return ROLE_WORD_START;
			end
		endcase
	endfunction

	function automatic result_t tokenize_word(item_t it);
		result_t           r;
		role_t             role;
		logic [PIPE_W-1:0] p0;
		logic [CMD_W-1:0]  c0;
		logic [ARG_W-1:0]  a0;
		logic              b0;
		logic [ARG_W-1:0]  ai;
		p0 = pipe_no;
		c0 = cmd_no;
		a0 = arg_no;
		b0 = bg;
		r = '0;
		if (it.end_of_line) begin
			if (err_latch == ERR_NONE) begin
				if (mode == LM_AFTER_GT)
					err_latch = ERR_NO_OUT_FILE;
				else if (mode == LM_AWAIT)
					err_latch = (pend_kind == NK_IN) ? ERR_NO_IN_FILE : ERR_NO_OUT_FILE;
				else if (cmds_in_pipe != 0 && arg_no == 0)
					err_latch = ERR_TRAILING;
			end
			if (err_latch == ERR_NONE)
				r.pipeline_count = (cmds_in_pipe != 0) ? 5'(pipe_no) + 5'd1 : 5'(pipe_no);
			r.role = ROLE_LINE_END;
			r.line_done = 1'b1;
			r.pipeline_index = p0[3:0];
			r.command_index = c0[3:0];
			r.argument_index = a0[5:0];
			r.background = b0;
			r.error_code = err_latch;
			clear_lexer();
		end else begin
			if (err_latch != ERR_NONE || it.ch == CH_NUL)
				role = ROLE_IGNORED;
			else
				role = lex_char(it.ch);
			r.role = role;
			if (role == ROLE_PIPE || role == ROLE_SEMI) begin
				r.pipeline_index = p0[3:0];
				r.command_index = c0[3:0];
				r.argument_index = a0[5:0];
				r.background = b0;
			end else begin
				ai = arg_no;
				if ((role == ROLE_WORD_START || role == ROLE_WORD_CONT) && arg_no != 0)
					ai = arg_no - 1'b1;
				r.pipeline_index = pipe_no[3:0];
				r.command_index = cmd_no[3:0];
				r.argument_index = ai[5:0];
				r.background = bg;
			end
			r.error_code = err_latch;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		$display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic check_result(result_t got, result_t want);
		if (got.role != want.role)
			report_mismatch("role", got.role, want.role);
		if (got.pipeline_index != want.pipeline_index)
			report_mismatch("pipeline_index", got.pipeline_index, want.pipeline_index);
		if (got.command_index != want.command_index)
			report_mismatch("command_index", got.command_index, want.command_index);
		if (got.argument_index != want.argument_index)
			report_mismatch("argument_index", got.argument_index, want.argument_index);
		if (got.background != want.background)
			report_mismatch("background", got.background, want.background);
		if (got.error_code != want.error_code)
			report_mismatch("error_code", got.error_code, want.error_code);
		if (got.pipeline_count != want.pipeline_count)
			report_mismatch("pipeline_count", got.pipeline_count, want.pipeline_count);
		if (got.line_done != want.line_done)
			report_mismatch("line_done", got.line_done, want.line_done);
	endtask

	// stimulus builders
	task automatic put_ch(logic [7:0] c);
		item_t it;
		it.ch = c;
		it.end_of_line = 1'b0;
		line_chars.push_back(it);
		queued_words++;
	endtask

	task automatic put_eol();
		item_t it;
		it.ch = 8'($urandom);
		it.end_of_line = 1'b1;
		line_chars.push_back(it);
		queued_words++;
		lines_queued++;
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_ch(s[i]);
	endtask

	function automatic logic [7:0] pick_word_char(bit first);
		logic [7:0] c;
		if ($urandom_range(0, 9) < 7)
			return 8'($urandom_range(97, 122));
		do
			c = 8'($urandom_range(1, 255));
		while (ends_token(c) || (first && blank_any(c)));
		return c;
	endfunction

	function automatic logic [7:0] pick_symbol();
		case ($urandom_range(0, 4))
			0: return CH_PIPE;
			1: return CH_SEMI;
			2: return CH_AMP;
			3: return CH_LT;
			default: return CH_GT;
		endcase
	endfunction

	task automatic put_word();
		int n;
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++)
			put_ch(pick_word_char(i == 0));
	endtask

	// first blank must end a word; later ones may be any blank
	task automatic put_gap(bit need);
		int n;
		n = need ? $urandom_range(1, 2) : $urandom_range(0, 1);
		for (int i = 0; i < n; i++) begin
			if (i == 0) begin
				case ($urandom_range(0, 2))
					0: put_ch(CH_SPACE);
					1: put_ch(CH_TAB);
					default: put_ch(CH_NL);
				endcase
			end else
				put_ch($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13)));
		end
	endtask

	task automatic put_command();
		int n;
		n = $urandom_range(1, 3);
		put_word();
		for (int i = 1; i < n; i++) begin
			put_gap(1'b1);
			put_word();
		end
		if ($urandom_range(0, 9) < 4) begin
			put_gap(1'b0);
			case ($urandom_range(0, 2))
				0: put_ch(CH_LT);
				1: put_ch(CH_GT);
				default: begin
					put_ch(CH_GT);
					put_ch(CH_GT);
				end
			endcase
			put_gap(1'b0);
			put_word();
		end
	endtask

	task automatic put_line();
		int np;
		int nc;
		np = $urandom_range(1, 3);
		for (int p = 0; p < np; p++) begin
			if (p != 0) begin
				put_gap(1'b0);
				put_ch(CH_SEMI);
				put_gap(1'b0);
			end
			nc = $urandom_range(1, 3);
			for (int c = 0; c < nc; c++) begin
				if (c != 0) begin
					put_gap(1'b0);
					put_ch(CH_PIPE);
					put_gap(1'b0);
				end
				put_command();
			end
			if ($urandom_range(0, 3) == 0) begin
				put_gap(1'b0);
				put_ch(CH_AMP);
			end
		end
		if ($urandom_range(0, 6) == 0)
			put_ch(CH_SEMI);
		put_eol();
	endtask

	task automatic put_noise_line();
		int n;
		n = $urandom_range(1, 12);
		repeat (n) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: put_ch(pick_symbol());
				4, 5: put_ch(8'($urandom_range(9, 13)));
				6, 7: put_ch(pick_word_char(1'b0));
				default: put_ch(8'($urandom));
			endcase
		end
		put_eol();
	endtask

	task automatic put_random_words(int count);
		int target;
		target = queued_words + count;
		while (queued_words < target) begin
			if ($urandom_range(0, 4) == 0)
				put_noise_line();
			else
				put_line();
		end
	endtask

	task automatic wait_drained();
		while (line_chars.size() != 0 || awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// driver: bursts with random gaps
	always @(negedge clk) begin
		if (in_taken) begin
			line_chars.delete(0);
			if (burst_left > 0)
				burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 30);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end
		end
		if (!arst_n || gap_left != 0 || line_chars.size() == 0) begin
			push <= 1'b0;
			if (arst_n && gap_left != 0)
				gap_left--;
		end else begin
			push <= 1'b1;
			item <= line_chars[0];
		end
	end

	// receiver: stall density follows a slow phase counter, plus one long hold
	always @(negedge clk) begin
		rx_phase++;
		if (!hold_done && results_checked >= HOLD_AT) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (!arst_n)
			pop <= 1'b0;
		else if (hold_left != 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			case (rx_phase[9:8])
				2'd0: pop <= 1'b1;
				2'd1: pop <= ($urandom_range(0, 3) != 0);
				2'd2: pop <= 1'($urandom_range(0, 1));
				default: pop <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// monitor
	always @(posedge clk) begin
		in_taken <= arst_n && push && !full;
		if (arst_n && pop && !empty) begin
			if (awaited_results.size() == 0)
				report_mismatch("word with nothing awaited, role", result.role, -1);
			else
				check_result(result, awaited_results.pop_front());
			results_checked++;
		end
		if (arst_n && push && !full)
			awaited_results.push_back(tokenize_word(item));
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		clear_lexer();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// NUL, top byte, append name with vertical tab inside, background
		put_ch(CH_NUL);
		put_ch(8'hff);
		put_text(">>b");
		put_ch(8'h0b);
		put_text("c&");
		put_eol();
		put_text("|");
		put_eol();
		put_text(";");
		put_eol();
		put_text("x|;");
		put_eol();
		put_text("y<");
		put_eol();
		put_text("z>");
		put_eol();
		put_text("q|");
		put_eol();
		wait_drained();

		// capacity: too many words, commands and pipelines, then the fullest legal line
		repeat (66) begin
			put_ch("w");
			put_ch(CH_SPACE);
		end
		put_eol();
		repeat (16) begin
			put_ch("a");
			put_ch(CH_PIPE);
		end
		put_eol();
		repeat (16) begin
			put_ch("a");
			put_ch(CH_SEMI);
		end
		put_eol();
		repeat (15) begin
			put_ch("a");
			put_ch(CH_SEMI);
		end
		put_ch("a");
		put_eol();
		put_random_words(70);
		wait_drained();

		put_random_words(70);
		wait_drained();
		repeat (8) @(posedge clk);

		$display("Sent %0d words over %0d lines (directed, capacity and random).",
			queued_words, lines_queued);
		$display("Compared %0d results; %0d field mismatches.", results_checked, mismatches);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/stc_pkg.sv
rtl/stc_front.sv
rtl/stc_back.sv
rtl/shell_command_line_tokenizer_core.sv
rtl/stc_checker.sv
dv/shell_command_line_tokenizer_core_tb.sv
